[rtl/core/las_pkg.sv]
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, widths, register indexes and the gaussian weight table of the
// lane angle smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package las_pkg;

    localparam int MAX_LINES          = 255;
    localparam int WEIGHT_TABLE_DEPTH = 128;

    localparam int ANGLE_LIMIT_Q8 = 23040;
    localparam int UNITY_Q16      = 65536;
    localparam int LINES_OUT_MAX  = 255;
    localparam int FOLD_LIMIT     = 90;
    localparam int HALF_TURN      = 180;

    localparam logic [63:0] STEP_FACTOR_Q32 = 64'd4287517225;
    localparam int          POW_STEPS       = 24;

    localparam int CNT_W   = $clog2(MAX_LINES + 1);
    localparam int IDX_W   = $clog2(WEIGHT_TABLE_DEPTH);
    localparam int EST_W   = 16;
    localparam int ANG_W   = 8;
    localparam int W_W     = 16;
    localparam int WT_W    = W_W + CNT_W;
    localparam int WAT_W   = 24 + CNT_W;
    localparam int AT_W    = ANG_W + CNT_W;
    localparam int MA_W    = EST_W + CNT_W;
    localparam int MB_W    = 18;
    localparam int MP_W    = MA_W + MB_W;
    localparam int NUM_W   = MP_W;
    localparam int DEN_W   = 17 + CNT_W;
    localparam int QW      = 16;
    localparam int QUOT_W  = QW + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_MODE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_INFLUENCE = CFG_IDX_W'(2);

    localparam logic MODE_GAUSSIAN = 1'b0;
    localparam logic MODE_MOVING   = 1'b1;

    typedef struct packed {
        logic [7:0] line_angle;
        logic       has_line;
        logic       frame_end;
    } las_in_t;

    typedef struct packed {
        logic signed [15:0] smoothed_angle;
        logic [7:0]         lines_used;
    } las_out_t;

    typedef logic [WEIGHT_TABLE_DEPTH-1:0][W_W-1:0] weight_table_t;

    // Q32.32 multiply with round to nearest
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
        return p[95:32];
    endfunction

    function automatic logic [63:0] pow_q32(input logic [63:0] base_in, input logic [31:0] e_in);
        logic [63:0] r;
        logic [63:0] base;
        logic [31:0] e;
        r    = 64'h1_0000_0000;
        base = base_in;
        e    = e_in;
        for (int k = 0; k < POW_STEPS; k++)
        begin
            if (e[0])
            begin
                r = mul_q32(r, base);
            end
            base = mul_q32(base, base);
            e    = e >> 1;
        end
        return r;
    endfunction

    // entry i = exp(-(i/4)^2/36) in Q0.16
    function automatic weight_table_t build_weight_table();
        weight_table_t t;
        logic [63:0]   p;
        logic [63:0]   w;
        for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++)
        begin
            p = pow_q32(STEP_FACTOR_Q32, 32'(i * i));
            w = (p + 64'h8000) >> 16;
            t[i] = (w > 64'd65535) ? 16'hFFFF : w[15:0];
        end
        return t;
    endfunction

    localparam weight_table_t WEIGHT_TABLE = build_weight_table();

endpackage

`default_nettype wire

[rtl/core/las_mul_unit.sv]
// ----------------------------------------------------------------------------
// las_mul_unit
// Shared signed multiplier with a registered product, time-shared by the
// sequencer for line weighting and the moving-average numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module las_mul_unit (
    input  logic                              clk,
    input  logic signed [las_pkg::MA_W-1:0]   a,
    input  logic signed [las_pkg::MB_W-1:0]   b,
    output logic signed [las_pkg::MP_W-1:0]   p
);
    import las_pkg::*;

    logic signed [MP_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MP_W'(a) * MP_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[rtl/core/las_div_unit.sv]
// ----------------------------------------------------------------------------
// las_div_unit
// Restoring divider, one quotient bit per cycle. Rounds to nearest with ties
// away from zero by dividing |num| + den/2 and restoring the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module las_div_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [las_pkg::NUM_W-1:0]    num,
    input  logic [las_pkg::DEN_W-1:0]           den,
    output logic                                done,
    output logic signed [las_pkg::QUOT_W-1:0]   quot
);
    import las_pkg::*;

    localparam int REM_W  = NUM_W + 1;
    localparam int DVS_W  = DEN_W + QW - 1;
    localparam int STEP_W = $clog2(QW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [QW-1:0]     q_reg, q_next;
    logic              neg_reg, neg_next;

    logic [NUM_W-1:0]  mag;
    logic              ge;

    always_comb
    begin
        mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ge  = rem_reg >= REM_W'(dvs_reg);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(QW);
            rem_next  = REM_W'(mag) + REM_W'(den >> 1);
            dvs_next  = DVS_W'(den) << (QW - 1);
            q_next    = '0;
            neg_next  = num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_reg - REM_W'(dvs_reg) : rem_reg;
            dvs_next  = dvs_reg >> 1;
            q_next    = {q_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - STEP_W'(1);
            busy_next = (cnt_reg != STEP_W'(1));
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};

endmodule

`default_nettype wire

[rtl/core/lane_angle_smoother_unit.sv]
// ----------------------------------------------------------------------------
// lane_angle_smoother_unit
// Smooths one steering angle per frame from Hough line angles.
//
// Input channel (in_valid/in_stall/in_data): one beat per line candidate;
// frame_end marks the last beat of a frame. in_stall is high while an item or
// frame result is worked on. A kept line is also multiplied and accumulated.
// Output channel (out_valid/out_stall/out_data): one beat per frame, carrying
// the new estimate in signed Q7.8 degrees and the kept line count.
// After the frame's last beat: moving-average mode runs three passes through
// the shared multiplier, then both modes run the divider, and the emit state
// loads the result into the output register.
// A frame with no kept lines skips the division and reports the old estimate.
// The output register holds a finished beat while out_stall is high; new
// input is still taken until the next frame result waits in the sequencer,
// with in_stall high, for the output register to free up.
// Reset clears the estimate and accumulators and loads register defaults
// (tilt limit 50, gaussian mode, blend_influence 3277). Configuration writes
// must be made by the user only while the block is idle; nothing checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_angle_smoother_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  las_pkg::las_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output las_pkg::las_out_t                  out_data,
    input  logic                               cfg_write_en,
    input  logic [las_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [las_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import las_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOOK  = 4'd1;
    localparam logic [3:0] ST_MULW  = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_FRAME = 4'd4;
    localparam logic [3:0] ST_M1    = 4'd5;
    localparam logic [3:0] ST_M2    = 4'd6;
    localparam logic [3:0] ST_M3    = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    // control state
    logic [3:0]              state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic [6:0]              tilt_limit_reg, tilt_limit_next;
    logic                    mode_reg, mode_next;
    logic [15:0]             blend_reg, blend_next;
    logic signed [EST_W-1:0] est_reg, est_next;
    logic [WT_W-1:0]         wt_reg, wt_next;
    logic signed [WAT_W-1:0] wat_reg, wat_next;
    logic signed [AT_W-1:0]  at_reg, at_next;
    logic [CNT_W-1:0]        kept_reg, kept_next;

    // payload
    las_in_t                 item_reg, item_next;
    logic [W_W-1:0]          w_reg, w_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    logic signed [NUM_W-1:0] term1_reg, term1_next;
    las_out_t                out_data_reg, out_data_next;

    logic [8:0]              ang9;
    logic signed [ANG_W-1:0] ang;
    logic [ANG_W-1:0]        mag;
    logic                    keep;
    logic signed [16:0]      dist_q8;
    logic [16:0]             abs_d;
    logic [10:0]             dist_idx;
    logic [W_W-1:0]          w_look;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;

    logic                    div_start;
    logic signed [NUM_W-1:0] div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic signed [QUOT_W-1:0] div_quot;

    logic signed [NUM_W-1:0] num_gauss;
    logic signed [NUM_W-1:0] num_blend;
    logic [DEN_W-1:0]        den_gauss;
    logic [DEN_W-1:0]        den_blend;
    logic                    accept;
    logic                    out_free;

    las_mul_unit u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    las_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // line fold, angle test and weight lookup
    always_comb
    begin
        ang9 = ({1'b0, item_reg.line_angle} > 9'(FOLD_LIMIT))
             ? {1'b0, item_reg.line_angle} - 9'(HALF_TURN)
             : {1'b0, item_reg.line_angle};
        ang  = ang9[ANG_W-1:0];
        mag  = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
        keep = item_reg.has_line && (mag <= {1'b0, tilt_limit_reg})
             && (32'(kept_reg) < MAX_LINES);
        dist_q8  = (17'(ang) <<< 8) - 17'(est_reg);
        abs_d    = dist_q8[16] ? 17'(-dist_q8) : 17'(dist_q8);
        dist_idx = abs_d[16:6];
        w_look   = (32'(dist_idx) < WEIGHT_TABLE_DEPTH)
                 ? WEIGHT_TABLE[dist_idx[IDX_W-1:0]] : '0;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MULW:
            begin
                mul_a = MA_W'({1'b0, w_reg});
                mul_b = MB_W'(ang_reg);
            end
            ST_FRAME:
            begin
                mul_a = MA_W'(est_reg);
                mul_b = MB_W'({1'b0, kept_reg});
            end
            ST_M1:
            begin
                mul_a = mul_p[MA_W-1:0];
                mul_b = MB_W'(18'(UNITY_Q16) - {2'b00, blend_reg});
            end
            ST_M2:
            begin
                mul_a = MA_W'(at_reg);
                mul_b = MB_W'({1'b0, blend_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign num_gauss = (NUM_W'(est_reg) <<< 16) + (NUM_W'(wat_reg) <<< 8);
    assign den_gauss = DEN_W'(UNITY_Q16) + DEN_W'(wt_reg);
    assign num_blend = term1_reg + (mul_p <<< 8);
    assign den_blend = DEN_W'(kept_reg) << 16;

    assign div_start = ((state_reg == ST_FRAME) && (kept_reg != '0)
                        && (mode_reg == MODE_GAUSSIAN))
                     || (state_reg == ST_M3);
    assign div_num   = (state_reg == ST_M3) ? num_blend : num_gauss;
    assign div_den   = (state_reg == ST_M3) ? den_blend : den_gauss;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        tilt_limit_next = tilt_limit_reg;
        mode_next       = mode_reg;
        blend_next      = blend_reg;
        est_next        = est_reg;
        wt_next         = wt_reg;
        wat_next        = wat_reg;
        at_next         = at_reg;
        kept_next       = kept_reg;
        item_next       = item_reg;
        w_next          = w_reg;
        ang_next        = ang_reg;
        term1_next      = term1_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_TILT_LIMIT:      tilt_limit_next = cfg_data[6:0];
                CFG_SMOOTHING_MODE:  mode_next       = cfg_data[0];
                CFG_BLEND_INFLUENCE: blend_next      = cfg_data[15:0];
                default:             ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = in_data;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                w_next   = w_look;
                ang_next = ang;
                if (keep)
                begin
                    state_next = ST_MULW;
                end
                else
                begin
                    state_next = item_reg.frame_end ? ST_FRAME : ST_IDLE;
                end
            end
            ST_MULW:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                wt_next    = wt_reg + WT_W'(w_reg);
                wat_next   = wat_reg + mul_p[WAT_W-1:0];
                at_next    = at_reg + AT_W'(ang_reg);
                kept_next  = kept_reg + CNT_W'(1);
                state_next = item_reg.frame_end ? ST_FRAME : ST_IDLE;
            end
            ST_FRAME:
            begin
                if (kept_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else if (mode_reg == MODE_GAUSSIAN)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                state_next = ST_M2;
            end
            ST_M2:
            begin
                term1_next = mul_p;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_quot > QUOT_W'(ANGLE_LIMIT_Q8))
                    begin
                        est_next = EST_W'(ANGLE_LIMIT_Q8);
                    end
                    else if (div_quot < QUOT_W'(-ANGLE_LIMIT_Q8))
                    begin
                        est_next = EST_W'(-ANGLE_LIMIT_Q8);
                    end
                    else
                    begin
                        est_next = div_quot[EST_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.smoothed_angle = est_reg;
                    out_data_next.lines_used     = (32'(kept_reg) > LINES_OUT_MAX)
                                                 ? 8'(LINES_OUT_MAX) : 8'(kept_reg);
                    wt_next    = '0;
                    wat_next   = '0;
                    at_next    = '0;
                    kept_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            tilt_limit_reg <= 7'd50;
            mode_reg       <= MODE_GAUSSIAN;
            blend_reg      <= 16'd3277;
            est_reg        <= '0;
            wt_reg         <= '0;
            wat_reg        <= '0;
            at_reg         <= '0;
            kept_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            tilt_limit_reg <= tilt_limit_next;
            mode_reg       <= mode_next;
            blend_reg      <= blend_next;
            est_reg        <= est_next;
            wt_reg         <= wt_next;
            wat_reg        <= wat_next;
            at_reg         <= at_next;
            kept_reg       <= kept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        w_reg        <= w_next;
        ang_reg      <= ang_next;
        term1_reg    <= term1_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
